// ===== hw/rtl/dtrs_pkg.sv =====
// Package for the dual trackball rotate and scroll block.
// Holds the default widths, register index codes, the quarter-wave sine table
// and small saturation helpers. Depends on nothing.
`default_nettype none

package dtrs_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int TRIG_BITS_DEF = 14;

   typedef enum logic [3:0] {
      CSR_LEFT_ANGLE    = 4'd0,
      CSR_RIGHT_ANGLE   = 4'd1,
      CSR_LEFT_INV_X    = 4'd2,
      CSR_RIGHT_INV_X   = 4'd3,
      CSR_LEFT_SCROLL   = 4'd4,
      CSR_RIGHT_SCROLL  = 4'd5,
      CSR_INVERT_SCROLL = 4'd6,
      CSR_DIVISOR       = 4'd7
   } csr_index_type;

   localparam logic [14:0] SIN_Q14 [0:90] = '{
          0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
       2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
       5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
       8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
      10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
      12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
      14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
      15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
      16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
      16384
   };

   function automatic logic [14:0] sin_q14(input logic [6:0] i);
      return (i <= 7'd90) ? SIN_Q14[i] : 15'd0;
   endfunction

   function automatic logic signed [7:0] sat8(input logic signed [9:0] v);
      logic signed [7:0] r;
      if (v > 10'sd127) begin
         r = 8'sd127;
      end else if (v < -10'sd128) begin
         r = -8'sd128;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

   function automatic logic signed [7:0] neg_sat8(input logic signed [7:0] v);
      return (v == 8'sh80) ? 8'sd127 : -v;
   endfunction

   function automatic logic [8:0] abs9(input logic signed [7:0] v);
      logic signed [8:0] e;
      e = {v[7], v};
      return e[8] ? unsigned'(-e) : unsigned'(e);
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dtrs_trig.sv =====
// Sine and cosine lookup for one angle in degrees, scaled to TRIG_BITS fraction bits.
// Uses the quarter-wave table of dtrs_pkg.
`default_nettype none

module dtrs_trig import dtrs_pkg::*; #(
   parameter int TRIG_BITS = TRIG_BITS_DEF,
   localparam int TV_W = TRIG_BITS + 2
) (
   input  wire logic        [8:0]      angle,
   output logic signed      [TV_W-1:0] sin_val,
   output logic signed      [TV_W-1:0] cos_val
);

   localparam int UP_SH = (TRIG_BITS >= 14) ? TRIG_BITS - 14 : 0;
   localparam int DN_SH = (TRIG_BITS < 14) ? 14 - TRIG_BITS : 0;
   localparam logic [15:0] RND = (TRIG_BITS < 14) ? 16'(1 << (13 - TRIG_BITS)) : 16'd0;

   function automatic logic signed [TV_W-1:0] scale_q14(input logic [14:0] q);
      logic [15:0] rnd;
      logic signed [TV_W-1:0] r;
      rnd = {1'b0, q} + RND;
      if (TRIG_BITS >= 14) begin
         r = TV_W'({1'b0, q}) << UP_SH;
      end else begin
         r = TV_W'(rnd >> DN_SH);
      end
      return r;
   endfunction

   function automatic logic signed [TV_W-1:0] trig_at(input logic [8:0] d);
      logic [8:0] idx;
      logic neg;
      logic signed [TV_W-1:0] mag;
      if (d <= 9'd90) begin
         idx = d;
         neg = 1'b0;
      end else if (d <= 9'd180) begin
         idx = 9'd180 - d;
         neg = 1'b0;
      end else if (d <= 9'd270) begin
         idx = d - 9'd180;
         neg = 1'b1;
      end else begin
         idx = 9'd360 - d;
         neg = 1'b1;
      end
      mag = scale_q14(sin_q14(idx[6:0]));
      return neg ? -mag : mag;
   endfunction

   logic [8:0] ang_red;
   logic [8:0] ang_90;
   logic [8:0] ang_cos;

   assign ang_red = (angle >= 9'd360) ? angle - 9'd360 : angle;
   assign ang_90  = ang_red + 9'd90;
   assign ang_cos = (ang_90 >= 9'd360) ? ang_90 - 9'd360 : ang_90;

   assign sin_val = trig_at(ang_red);
   assign cos_val = trig_at(ang_cos);

endmodule

`default_nettype wire

// ===== hw/rtl/dtrs_div.sv =====
// Shared restoring divider, one quotient bit per cycle: (magnitude * 2^FRAC_BITS) / divisor.
// Uses dtrs_pkg for the default fraction width.
`default_nettype none

module dtrs_div import dtrs_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   localparam int QW = FRAC_BITS + 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [7:0]    magnitude,
   input  wire logic [7:0]    divisor,
   output logic               busy,
   output logic [QW-1:0]      quotient
);

   localparam int CW = $clog2(QW + 1);

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [8:0]    rem_ff, rem_in;
   logic [QW-1:0] num_ff, num_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [7:0]    dvs_ff, dvs_in;
   logic [8:0]    trial;
   logic          fits;

   assign trial = {rem_ff[7:0], num_ff[QW-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(QW);
         rem_in  = '0;
         num_in  = {magnitude, {FRAC_BITS{1'b0}}};
         quo_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? trial - {1'b0, dvs_ff} : trial;
         num_in = {num_ff[QW-2:0], 1'b0};
         quo_in = {quo_ff[QW-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/dual_trackball_rotate_scroll.sv =====
// Top level of the dual trackball rotate and scroll block: sequencer, shared multiplier,
// registers and scroll residues. Instantiates dtrs_trig and dtrs_div; uses dtrs_pkg.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    left_dx, left_dy, right_dx, right_dy, scroll_hold
//   rsp      out        rsp_valid/rsp_ready    left/right x, y, h, v
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// A request runs through the angle lookup, the multiply steps and rounding for each ball
// in turn; a ball in scroll mode also runs the bit-serial divider for its horizontal and
// vertical residue increments. Requests are taken only while the sequencer is idle; a
// finished result waits in the output register while the next request is accepted and processed.
// Reset is synchronous and clears the registers to their defaults and all residues to zero.
`default_nettype none

module dual_trackball_rotate_scroll import dtrs_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int TRIG_BITS = TRIG_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic signed [7:0] req_left_dx,
   input  wire logic signed [7:0] req_left_dy,
   input  wire logic signed [7:0] req_right_dx,
   input  wire logic signed [7:0] req_right_dy,
   input  wire logic              req_scroll_hold,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic signed      [7:0] rsp_left_x,
   output logic signed      [7:0] rsp_left_y,
   output logic signed      [7:0] rsp_left_h,
   output logic signed      [7:0] rsp_left_v,
   output logic signed      [7:0] rsp_right_x,
   output logic signed      [7:0] rsp_right_y,
   output logic signed      [7:0] rsp_right_h,
   output logic signed      [7:0] rsp_right_v,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic        [3:0] csr_index,
   input  wire logic        [8:0] csr_data
);

   localparam int TV_W  = TRIG_BITS + 2;
   localparam int AW    = TRIG_BITS + 10;
   localparam int QW    = FRAC_BITS + 8;
   localparam int SQW   = FRAC_BITS + 9;
   localparam int RW    = FRAC_BITS + 10;
   localparam int RES_W = FRAC_BITS + 1;
   localparam logic [AW-1:0] ROT_BIAS = AW'((1 << TRIG_BITS) - 1);
   localparam logic [RW-1:0] RES_BIAS = RW'((1 << FRAC_BITS) - 1);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_TRIG   = 9'b000000010,
      S_MUL    = 9'b000000100,
      S_ROT    = 9'b000001000,
      S_MODE   = 9'b000010000,
      S_DSTART = 9'b000100000,
      S_DWAIT  = 9'b001000000,
      S_ACC    = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

   function automatic logic signed [9:0] rot_trunc(input logic signed [AW-1:0] v);
      logic signed [AW-1:0] adj;
      adj = v + (v[AW-1] ? ROT_BIAS : '0);
      return adj[AW-1:TRIG_BITS];
   endfunction

   state_type state_ff, state_in;
   logic       ball_ff, ball_in;
   logic       axis_ff, axis_in;
   logic [1:0] step_ff, step_in;

   logic [8:0] left_angle_ff, left_angle_in;
   logic [8:0] right_angle_ff, right_angle_in;
   logic [1:0] inv_x_ff, inv_x_in;
   logic [1:0] scroll_mode_ff, scroll_mode_in;
   logic       invert_scroll_ff, invert_scroll_in;
   logic [7:0] divisor_ff, divisor_in;

   logic signed [7:0] dx_ff [2], dx_in [2];
   logic signed [7:0] dy_ff [2], dy_in [2];
   logic              hold_ff, hold_in;

   logic signed [TV_W-1:0] sin_ff, sin_in, cos_ff, cos_in;
   logic signed [AW-1:0]   xacc_ff, xacc_in, yacc_ff, yacc_in;
   logic signed [7:0]      x_ff, x_in, y_ff, y_in;
   logic signed [7:0]      sv_ff [2], sv_in [2];
   logic signed [7:0]      res_x_ff [2], res_x_in [2];
   logic signed [7:0]      res_y_ff [2], res_y_in [2];
   logic signed [7:0]      res_h_ff [2], res_h_in [2];
   logic signed [7:0]      res_v_ff [2], res_v_in [2];
   logic signed [RES_W-1:0] residue_ff [4], residue_in [4];

   logic signed [7:0] out_x_ff [2], out_x_in [2];
   logic signed [7:0] out_y_ff [2], out_y_in [2];
   logic signed [7:0] out_h_ff [2], out_h_in [2];
   logic signed [7:0] out_v_ff [2], out_v_in [2];
   logic              rsp_valid_ff, rsp_valid_in;

   logic [8:0]             trig_angle;
   logic signed [TV_W-1:0] trig_sin, trig_cos;
   logic signed [7:0]      mul_a;
   logic signed [TV_W-1:0] mul_b;
   logic signed [AW-1:0]   prod;
   logic                   div_start, div_busy;
   logic [QW-1:0]          div_quo;
   logic [7:0]             div_eff;
   logic [8:0]             div_mag;
   logic signed [7:0]      cur_sv;
   logic [1:0]             res_idx;

   logic signed [7:0]      rx, ry;
   logic [8:0]             ax, ay;
   logic signed [7:0]      hx, vy;
   logic signed [SQW-1:0]  sq;
   logic signed [RW-1:0]   acc, acc_adj, rem_full;
   logic signed [9:0]      whole;

   assign trig_angle = ball_ff ? right_angle_ff : left_angle_ff;

   dtrs_trig #(.TRIG_BITS(TRIG_BITS)) u_trig (
      .angle   (trig_angle),
      .sin_val (trig_sin),
      .cos_val (trig_cos)
   );

   assign mul_a = (step_ff == 2'd0 || step_ff == 2'd3) ? dx_ff[ball_ff] : dy_ff[ball_ff];
   assign mul_b = (step_ff == 2'd0 || step_ff == 2'd2) ? cos_ff : sin_ff;
   assign prod  = AW'(mul_a) * AW'(mul_b);

   assign div_eff = (divisor_ff == 8'd0) ? 8'd1 : divisor_ff;
   assign cur_sv  = sv_ff[axis_ff];
   assign div_mag = abs9(cur_sv);
   assign res_idx = {ball_ff, axis_ff};

   dtrs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .magnitude (div_mag[7:0]),
      .divisor   (div_eff),
      .busy      (div_busy),
      .quotient  (div_quo)
   );

   always_comb begin
      rx = sat8(rot_trunc(xacc_ff));
      if (inv_x_ff[ball_ff]) begin
         rx = neg_sat8(rx);
      end
      ry = sat8(rot_trunc(yacc_ff));

      ax = abs9(x_ff);
      ay = abs9(y_ff);
      hx = (ax > ay) ? x_ff : 8'sd0;
      vy = (ax > ay) ? 8'sd0 : y_ff;
      if (!invert_scroll_ff) begin
         hx = neg_sat8(hx);
         vy = neg_sat8(vy);
      end

      sq       = cur_sv[7] ? -SQW'(div_quo) : SQW'(div_quo);
      acc      = RW'(residue_ff[res_idx]) + RW'(sq);
      acc_adj  = acc + (acc[RW-1] ? RES_BIAS : '0);
      whole    = acc_adj[RW-1:FRAC_BITS];
      rem_full = acc - {whole, {FRAC_BITS{1'b0}}};
   end

   always_comb begin
      state_in = state_ff;
      ball_in  = ball_ff;
      axis_in  = axis_ff;
      step_in  = step_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      hold_in  = hold_ff;
      sin_in   = sin_ff;
      cos_in   = cos_ff;
      xacc_in  = xacc_ff;
      yacc_in  = yacc_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      sv_in    = sv_ff;
      res_x_in = res_x_ff;
      res_y_in = res_y_ff;
      res_h_in = res_h_ff;
      res_v_in = res_v_ff;
      residue_in = residue_ff;
      out_x_in = out_x_ff;
      out_y_in = out_y_ff;
      out_h_in = out_h_ff;
      out_v_in = out_v_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      div_start = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dx_in[0] = req_left_dx;
               dy_in[0] = req_left_dy;
               dx_in[1] = req_right_dx;
               dy_in[1] = req_right_dy;
               hold_in  = req_scroll_hold;
               ball_in  = 1'b0;
               state_in = S_TRIG;
            end
         end
         S_TRIG: begin
            sin_in   = trig_sin;
            cos_in   = trig_cos;
            step_in  = 2'd0;
            state_in = S_MUL;
         end
         S_MUL: begin
            case (step_ff)
               2'd0:    xacc_in = prod;
               2'd1:    xacc_in = xacc_ff + prod;
               2'd2:    yacc_in = prod;
               default: yacc_in = yacc_ff - prod;
            endcase
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = S_ROT;
            end
         end
         S_ROT: begin
            x_in     = rx;
            y_in     = ry;
            state_in = S_MODE;
         end
         S_MODE: begin
            if (hold_ff || scroll_mode_ff[ball_ff]) begin
               sv_in[0]          = hx;
               sv_in[1]          = vy;
               res_x_in[ball_ff] = 8'sd0;
               res_y_in[ball_ff] = 8'sd0;
               axis_in           = 1'b0;
               state_in          = S_DSTART;
            end else begin
               res_x_in[ball_ff] = neg_sat8(x_ff);
               res_y_in[ball_ff] = y_ff;
               res_h_in[ball_ff] = 8'sd0;
               res_v_in[ball_ff] = 8'sd0;
               ball_in           = 1'b1;
               state_in          = ball_ff ? S_DONE : S_TRIG;
            end
         end
         S_DSTART: begin
            div_start = 1'b1;
            state_in  = S_DWAIT;
         end
         S_DWAIT: begin
            if (!div_busy) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            residue_in[res_idx] = rem_full[RES_W-1:0];
            if (axis_ff) begin
               res_v_in[ball_ff] = sat8(whole);
               ball_in           = 1'b1;
               state_in          = ball_ff ? S_DONE : S_TRIG;
            end else begin
               res_h_in[ball_ff] = sat8(whole);
               axis_in           = 1'b1;
               state_in          = S_DSTART;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_x_in     = res_x_ff;
               out_y_in     = res_y_ff;
               out_h_in     = res_h_ff;
               out_v_in     = res_v_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      left_angle_in    = left_angle_ff;
      right_angle_in   = right_angle_ff;
      inv_x_in         = inv_x_ff;
      scroll_mode_in   = scroll_mode_ff;
      invert_scroll_in = invert_scroll_ff;
      divisor_in       = divisor_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LEFT_ANGLE:    left_angle_in     = csr_data;
            CSR_RIGHT_ANGLE:   right_angle_in    = csr_data;
            CSR_LEFT_INV_X:    inv_x_in[0]       = csr_data[0];
            CSR_RIGHT_INV_X:   inv_x_in[1]       = csr_data[0];
            CSR_LEFT_SCROLL:   scroll_mode_in[0] = csr_data[0];
            CSR_RIGHT_SCROLL:  scroll_mode_in[1] = csr_data[0];
            CSR_INVERT_SCROLL: invert_scroll_in  = csr_data[0];
            CSR_DIVISOR:       divisor_in        = csr_data[7:0];
            default:           ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         ball_ff          <= 1'b0;
         axis_ff          <= 1'b0;
         step_ff          <= 2'd0;
         rsp_valid_ff     <= 1'b0;
         left_angle_ff    <= 9'd0;
         right_angle_ff   <= 9'd0;
         inv_x_ff         <= 2'b00;
         scroll_mode_ff   <= 2'b01;
         invert_scroll_ff <= 1'b0;
         divisor_ff       <= 8'd8;
         residue_ff       <= '{default: '0};
      end else begin
         state_ff         <= state_in;
         ball_ff          <= ball_in;
         axis_ff          <= axis_in;
         step_ff          <= step_in;
         rsp_valid_ff     <= rsp_valid_in;
         left_angle_ff    <= left_angle_in;
         right_angle_ff   <= right_angle_in;
         inv_x_ff         <= inv_x_in;
         scroll_mode_ff   <= scroll_mode_in;
         invert_scroll_ff <= invert_scroll_in;
         divisor_ff       <= divisor_in;
         residue_ff       <= residue_in;
      end
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      hold_ff  <= hold_in;
      sin_ff   <= sin_in;
      cos_ff   <= cos_in;
      xacc_ff  <= xacc_in;
      yacc_ff  <= yacc_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      sv_ff    <= sv_in;
      res_x_ff <= res_x_in;
      res_y_ff <= res_y_in;
      res_h_ff <= res_h_in;
      res_v_ff <= res_v_in;
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
      out_h_ff <= out_h_in;
      out_v_ff <= out_v_in;
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_left_x  = out_x_ff[0];
   assign rsp_left_y  = out_y_ff[0];
   assign rsp_left_h  = out_h_ff[0];
   assign rsp_left_v  = out_v_ff[0];
   assign rsp_right_x = out_x_ff[1];
   assign rsp_right_y = out_y_ff[1];
   assign rsp_right_h = out_h_ff[1];
   assign rsp_right_v = out_v_ff[1];

endmodule

`default_nettype wire

// ===== test/tb_dual_trackball_rotate_scroll.sv =====
// Self-checking testbench for dual_trackball_rotate_scroll: it drives motion requests
// and register writes and checks every report against its own motion predictor.
// Depends on dtrs_pkg and the dual_trackball_rotate_scroll RTL.
module tb_dual_trackball_rotate_scroll;
   import dtrs_pkg::*;

   localparam int FRAC_BITS = 16;
   localparam int TRIG_BITS = 14;
   localparam longint FRAC_ONE = longint'(1) << FRAC_BITS;
   localparam longint TRIG_ONE = longint'(1) << TRIG_BITS;
   localparam int REG_COUNT = 8;
   localparam logic [3:0] UNUSED_INDEX_LOW = 4'd8;
   localparam logic [3:0] UNUSED_INDEX_HIGH = 4'd15;
   localparam int ITEM_TARGET = 2000;
   localparam int LONG_HOLD = 1500;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int END_TAIL = 300;

   typedef struct {
      logic signed [7:0] left_dx;
      logic signed [7:0] left_dy;
      logic signed [7:0] right_dx;
      logic signed [7:0] right_dy;
      logic              scroll_hold;
   } motion_t;

   typedef logic [7:0][7:0] report_t;

   typedef enum int {READY_ALWAYS, READY_HALF, READY_RARE} stall_pattern_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [7:0] req_left_dx = '0;
   logic signed [7:0] req_left_dy = '0;
   logic signed [7:0] req_right_dx = '0;
   logic signed [7:0] req_right_dy = '0;
   logic req_scroll_hold = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [7:0] rsp_left_x, rsp_left_y, rsp_left_h, rsp_left_v;
   logic signed [7:0] rsp_right_x, rsp_right_y, rsp_right_h, rsp_right_v;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [3:0] csr_index = '0;
   logic [8:0] csr_data = '0;

   int sine_table [91] = '{
          0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
       2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
       5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
       8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
      10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
      12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
      14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
      15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
      16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
      16384
   };
   string report_field [8] = '{"left_x", "left_y", "left_h", "left_v",
                               "right_x", "right_y", "right_h", "right_v"};

   int reg_value [REG_COUNT] = '{0, 0, 0, 0, 1, 0, 0, 8};
   longint scroll_residue [4] = '{0, 0, 0, 0};

   motion_t pending_motion [$];
   report_t expected_reports [$];
   int mismatch_count = 0;
   int reports_seen = 0;
   int random_total = 0;

   int burst_left = 1;
   int gap_left = 0;
   logic offer_next;

   int hold_left = 0;
   int pattern_left = 0;
   stall_pattern_t stall_pattern = READY_ALWAYS;
   report_t wanted, actual;

   int stall_cycles = 0;

   dual_trackball_rotate_scroll #(.FRAC_BITS(FRAC_BITS), .TRIG_BITS(TRIG_BITS)) dut (.*);

   always #1 clock = ~clock;

   function automatic int clamp8(longint v);
      if (v > 127) return 127;
      if (v < -128) return -128;
      return int'(v);
   endfunction

   function automatic int sine_deg(int d);
      d = d % 360;
      if (d <= 90) return sine_table[d] <<< (TRIG_BITS - 14);
      if (d <= 180) return sine_table[180 - d] <<< (TRIG_BITS - 14);
      if (d <= 270) return -(sine_table[d - 180] <<< (TRIG_BITS - 14));
      return -(sine_table[360 - d] <<< (TRIG_BITS - 14));
   endfunction

   function automatic int accumulate(int slot, int v);
      longint divisor, total, whole;
      divisor = (reg_value[CSR_DIVISOR] == 0) ? 1 : reg_value[CSR_DIVISOR];
      total = scroll_residue[slot] + (longint'(v) * FRAC_ONE) / divisor;
      whole = total / FRAC_ONE;
      scroll_residue[slot] = total - whole * FRAC_ONE;
      return clamp8(whole);
   endfunction

   function automatic logic [3:0][7:0] move_ball(int dx, int dy, int angle, bit invert_x,
                                                 bit scrolling, int slot);
      int a, s, c, x, y;
      logic [3:0][7:0] r;
      a = angle % 360;
      s = sine_deg(a);
      c = sine_deg(a + 90);
      x = clamp8((longint'(dx) * c + longint'(dy) * s) / TRIG_ONE);
      y = clamp8((longint'(dy) * c - longint'(dx) * s) / TRIG_ONE);
      r = '0;
      if (invert_x) x = clamp8(-x);
      if (scrolling) begin
         if ((x < 0 ? -x : x) > (y < 0 ? -y : y)) y = 0;
         else x = 0;
         if (reg_value[CSR_INVERT_SCROLL] == 0) begin
            x = clamp8(-x);
            y = clamp8(-y);
         end
         r[2] = 8'(accumulate(slot, x));
         r[3] = 8'(accumulate(slot + 1, y));
      end else begin
         r[0] = 8'(clamp8(-x));
         r[1] = 8'(y);
      end
      return r;
   endfunction

   function automatic report_t predict_report(logic signed [7:0] ldx, logic signed [7:0] ldy,
                                              logic signed [7:0] rdx, logic signed [7:0] rdy,
                                              logic hold);
      report_t r;
      r[3:0] = move_ball(ldx, ldy, reg_value[CSR_LEFT_ANGLE], reg_value[CSR_LEFT_INV_X] != 0,
                         hold || reg_value[CSR_LEFT_SCROLL] != 0, 0);
      r[7:4] = move_ball(rdx, rdy, reg_value[CSR_RIGHT_ANGLE], reg_value[CSR_RIGHT_INV_X] != 0,
                         hold || reg_value[CSR_RIGHT_SCROLL] != 0, 2);
      return r;
   endfunction

   function automatic logic [7:0] random_count();
      case ($urandom_range(0, 9))
         0: return 8'h80;
         1: return 8'h7f;
         2: return 8'h00;
         3, 4, 5: return 8'($urandom_range(0, 16) - 8);
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [8:0] random_angle();
      case ($urandom_range(0, 7))
         0: return 9'd0;
         1: return 9'd90;
         2: return 9'd180;
         3: return 9'd270;
         4: return 9'd359;
         5: return 9'($urandom_range(360, 511));
         default: return 9'($urandom_range(0, 511));
      endcase
   endfunction

   function automatic logic [8:0] random_divisor();
      logic [7:0] d;
      case ($urandom_range(0, 7))
         0: d = 8'd0;
         1: d = 8'd1;
         2: d = 8'd255;
         3, 4, 5: d = 8'($urandom_range(1, 16));
         default: d = 8'($urandom_range(1, 255));
      endcase
      return {1'($urandom), d};
   endfunction

   task automatic write_reg(input logic [3:0] index, input logic [8:0] data);
      @(posedge clock);
      csr_index <= index;
      csr_data <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_LEFT_ANGLE, CSR_RIGHT_ANGLE: reg_value[index] = data;
         CSR_LEFT_INV_X, CSR_RIGHT_INV_X, CSR_LEFT_SCROLL, CSR_RIGHT_SCROLL,
         CSR_INVERT_SCROLL: reg_value[index] = data[0];
         CSR_DIVISOR: reg_value[index] = data[7:0];
         default: ;
      endcase
   endtask

   task automatic add_motion(input logic [7:0] ldx, input logic [7:0] ldy,
                             input logic [7:0] rdx, input logic [7:0] rdy, input logic hold);
      motion_t m;
      m.left_dx = ldx;
      m.left_dy = ldy;
      m.right_dx = rdx;
      m.right_dy = rdy;
      m.scroll_hold = hold;
      pending_motion.push_back(m);
   endtask

   task automatic wait_drained();
      while (pending_motion.size() != 0 || expected_reports.size() != 0) @(posedge clock);
   endtask

   // Sender: offers pending requests in bursts separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offer_next = req_valid && !req_ready;
         if (req_valid && req_ready) begin
            expected_reports.push_back(predict_report(req_left_dx, req_left_dy, req_right_dx,
                                                      req_right_dy, req_scroll_hold));
            pending_motion.delete(0);
         end
         if (!offer_next) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_motion.size() != 0) begin
               offer_next = 1'b1;
               req_left_dx <= pending_motion[0].left_dx;
               req_left_dy <= pending_motion[0].left_dy;
               req_right_dx <= pending_motion[0].right_dx;
               req_right_dy <= pending_motion[0].right_dy;
               req_scroll_hold <= pending_motion[0].scroll_hold;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 30);
                  case ($urandom_range(0, 3))
                     0: gap_left = 0;
                     1: gap_left = $urandom_range(1, 8);
                     default: gap_left = $urandom_range(1, 150);
                  endcase
               end
            end
         end
         req_valid <= offer_next;
      end
   end

   // Receiver: checks each report and stalls on a changing pattern, with two long holds.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            actual = {rsp_right_v, rsp_right_h, rsp_right_y, rsp_right_x,
                      rsp_left_v, rsp_left_h, rsp_left_y, rsp_left_x};
            if (expected_reports.size() == 0) begin
               $display("%0t: report with none expected, actual %h", $time, actual);
               mismatch_count++;
            end else begin
               wanted = expected_reports.pop_front();
               for (int i = 0; i < 8; i++) begin
                  if (wanted[i] !== actual[i]) begin
                     $display("%0t: %s expected %0d actual %0d", $time, report_field[i],
                              $signed(wanted[i]), $signed(actual[i]));
                     mismatch_count++;
                  end
               end
            end
            reports_seen++;
            if (reports_seen == 400 || reports_seen == 1400) hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (pattern_left == 0) begin
               stall_pattern = stall_pattern_t'($urandom_range(0, 2));
               pattern_left = $urandom_range(20, 300);
            end else begin
               pattern_left--;
            end
            case (stall_pattern)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_HALF: rsp_ready <= 1'($urandom);
               default: rsp_ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int count;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: left ball scrolls, right ball points.
      @(negedge clock);
      add_motion(8'sd0, 8'sd0, 8'sd0, 8'sd0, 1'b0);
      add_motion(-8'sd128, -8'sd128, -8'sd128, -8'sd128, 1'b0);
      add_motion(8'sd127, 8'sd127, 8'sd127, 8'sd127, 1'b0);
      add_motion(-8'sd128, 8'sd127, 8'sd127, -8'sd128, 1'b1);
      add_motion(8'sd5, -8'sd3, -8'sd7, 8'sd2, 1'b0);
      repeat (3) add_motion(8'sd0, 8'sd1, 8'sd0, 8'sd1, 1'b1);
      wait_drained();

      write_reg(CSR_LEFT_ANGLE, 9'd360);
      write_reg(CSR_RIGHT_ANGLE, 9'd511);
      write_reg(CSR_LEFT_INV_X, 9'd1);
      write_reg(CSR_RIGHT_INV_X, 9'd1);
      write_reg(CSR_LEFT_SCROLL, 9'd0);
      write_reg(CSR_RIGHT_SCROLL, 9'd0);
      write_reg(CSR_INVERT_SCROLL, 9'd1);
      write_reg(CSR_DIVISOR, 9'd0);
      write_reg(UNUSED_INDEX_LOW, 9'h1ff);
      write_reg(UNUSED_INDEX_HIGH, 9'h000);
      @(negedge clock);
      add_motion(-8'sd128, 8'sd0, -8'sd128, 8'sd0, 1'b0);
      add_motion(8'sd0, -8'sd128, 8'sd0, 8'sd127, 1'b0);
      add_motion(-8'sd128, -8'sd128, 8'sd127, 8'sd127, 1'b1);
      add_motion(8'sd3, 8'sd4, -8'sd4, 8'sd3, 1'b1);
      wait_drained();

      write_reg(CSR_LEFT_ANGLE, 9'd90);
      write_reg(CSR_RIGHT_ANGLE, 9'd45);
      write_reg(CSR_LEFT_INV_X, 9'd0);
      write_reg(CSR_RIGHT_INV_X, 9'd0);
      write_reg(CSR_RIGHT_SCROLL, 9'd1);
      write_reg(CSR_INVERT_SCROLL, 9'd0);
      write_reg(CSR_DIVISOR, 9'd255);
      @(negedge clock);
      add_motion(8'sd127, -8'sd128, -8'sd128, 8'sd127, 1'b0);
      repeat (2) add_motion(8'sd100, 8'sd100, -8'sd100, -8'sd100, 1'b1);
      add_motion(8'sd1, 8'sd2, 8'sd3, 8'sd4, 1'b0);
      wait_drained();

      write_reg(CSR_LEFT_ANGLE, 9'd359);
      write_reg(CSR_RIGHT_ANGLE, 9'd180);
      write_reg(CSR_LEFT_SCROLL, 9'd1);
      write_reg(CSR_INVERT_SCROLL, 9'd1);
      write_reg(CSR_DIVISOR, 9'd1);
      @(negedge clock);
      add_motion(-8'sd128, -8'sd128, 8'sd127, -8'sd128, 1'b0);
      add_motion(8'sd127, -8'sd1, -8'sd1, 8'sd127, 1'b1);
      add_motion(-8'sd1, -8'sd1, 8'sd1, 8'sd1, 1'b0);
      wait_drained();

      while (random_total < ITEM_TARGET) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            case (csr_index_type'(i))
               CSR_LEFT_ANGLE, CSR_RIGHT_ANGLE: write_reg(4'(i), random_angle());
               CSR_DIVISOR: write_reg(4'(i), random_divisor());
               default: write_reg(4'(i), 9'($urandom));
            endcase
         end
         if ($urandom_range(0, 1) == 1) begin
            write_reg(4'($urandom_range(UNUSED_INDEX_LOW, UNUSED_INDEX_HIGH)), 9'($urandom));
         end
         count = $urandom_range(100, 300);
         @(negedge clock);
         repeat (count) begin
            add_motion(random_count(), random_count(), random_count(), random_count(),
                       $urandom_range(0, 2) == 0);
         end
         random_total += count;
         wait_drained();
      end

      repeat (END_TAIL) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
